FILE: design/pvkf_pkg.sv
package pvkf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_W    = 32;
	localparam int REG_W     = 31;
	localparam int QUOT_W    = WORD_W + FRAC_BITS;

	typedef logic signed [WORD_W-1:0]   word_t;
	typedef logic signed [2*WORD_W-1:0] prod_t;
	typedef logic        [REG_W-1:0]    cfg_word_t;
	typedef logic        [1:0]          cfg_index_t;

	localparam cfg_index_t REG_STEP_TIME      = 2'd0;
	localparam cfg_index_t REG_POSITION_NOISE = 2'd1;
	localparam cfg_index_t REG_VELOCITY_NOISE = 2'd2;
	localparam cfg_index_t REG_MEASURE_NOISE  = 2'd3;

	localparam cfg_word_t RST_STEP_TIME      = 31'd65536;
	localparam cfg_word_t RST_POSITION_NOISE = 31'd655;
	localparam cfg_word_t RST_VELOCITY_NOISE = 31'd655;
	localparam cfg_word_t RST_MEASURE_NOISE  = 31'd65536;

	localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam word_t ONE      = word_t'(1) <<< FRAC_BITS;

	function automatic word_t sat_add(word_t a, word_t b);
		logic signed [WORD_W:0] sum;
		sum = {a[WORD_W-1], a} + {b[WORD_W-1], b};
		if (sum[WORD_W] != sum[WORD_W-1]) begin
			return sum[WORD_W] ? WORD_MIN : WORD_MAX;
		end
		return sum[WORD_W-1:0];
	endfunction

	function automatic word_t sat_sub(word_t a, word_t b);
		logic signed [WORD_W:0] dif;
		dif = {a[WORD_W-1], a} - {b[WORD_W-1], b};
		if (dif[WORD_W] != dif[WORD_W-1]) begin
			return dif[WORD_W] ? WORD_MIN : WORD_MAX;
		end
		return dif[WORD_W-1:0];
	endfunction

	// product shifted right by the fraction bits, floor, then clamped
	function automatic word_t sat_mul(prod_t p);
		logic [2*WORD_W-1-FRAC_BITS-(WORD_W-1):0] top;
		top = p[2*WORD_W-1:WORD_W-1+FRAC_BITS];
		if (top != '0 && top != '1) begin
			return p[2*WORD_W-1] ? WORD_MIN : WORD_MAX;
		end
		return p[WORD_W-1+FRAC_BITS:FRAC_BITS];
	endfunction

	function automatic word_t abs_word(word_t a);
		return a[WORD_W-1] ? word_t'(-a) : a;
	endfunction

	function automatic word_t sat_quot(logic [QUOT_W-1:0] q, logic neg);
		if (neg) begin
			if (q[QUOT_W-1:WORD_W] != '0 || (q[WORD_W-1] && q[WORD_W-2:0] != '0)) begin
				return WORD_MIN;
			end
			return word_t'(-q[WORD_W-1:0]);
		end
		if (q[QUOT_W-1:WORD_W-1] != '0) begin
			return WORD_MAX;
		end
		return q[WORD_W-1:0];
	endfunction

endpackage

FILE: design/position_velocity_kalman_filter.sv
// Two-state constant-velocity Kalman tracker in signed Q16.16. Each measurement word runs a
// predict step and a position-only update step and yields one word with the new position and
// velocity. All products go through one 32x32 multiplier (multiply in S_MUL, then shift, clamp
// and accumulate in S_ACC) and both gain divisions through one restoring divider that retires
// one quotient bit per cycle. An item runs eleven products and two 48-bit gain divisions, then
// loads the output register; only then, back in S_IDLE, is the next word accepted.
// in_stall is high for the whole computation. A finished word waits in the output register
// while the next item is taken; the user must write configuration only while the block is idle,
// as the block itself does not enforce it.
module position_velocity_kalman_filter (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  pvkf_pkg::cfg_index_t   cfg_index,
	input  pvkf_pkg::cfg_word_t    cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  pvkf_pkg::word_t        measurement,
	output logic                   out_valid,
	input  logic                   out_stall,
	output pvkf_pkg::word_t        position_est,
	output pvkf_pkg::word_t        velocity_est
);
	import pvkf_pkg::*;

	localparam int DIV_STEPS = QUOT_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ACC,
		S_DIV,
		S_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_T00,
		OP_T01,
		OP_A00,
		OP_A10,
		OP_XP,
		OP_POS,
		OP_VEL,
		OP_P00,
		OP_P01,
		OP_P10,
		OP_P11
	} op_t;

	state_t    state_q;
	op_t       op_q;
	cfg_word_t dt_q, qp_q, qv_q, r_q;
	word_t     pos_q, vel_q, p00_q, p01_q, p10_q, p11_q;
	word_t     pos_est_q, vel_est_q;
	logic      out_valid_q;

	// scratch values of one update
	word_t     meas_q, a00_q, a01_q, a10_q, a11_q, xp_q, s_q, k0_q, k1_q, y_q, c_q;
	prod_t     prod_q;

	// divider
	logic [QUOT_W-1:0] num_q;
	word_t             rem_q;
	word_t             ms_q;
	logic              neg_q;
	logic              ksel_q;
	logic [CNT_W-1:0]  div_cnt_q;

	word_t dt, qp, qv, r;
	word_t opa, opb, mres, s_next, kq;
	logic [WORD_W:0]   trial;
	logic              take;
	word_t             rem_next;
	logic [QUOT_W-1:0] num_next;
	logic              div_last;

	assign dt = word_t'({1'b0, dt_q});
	assign qp = word_t'({1'b0, qp_q});
	assign qv = word_t'({1'b0, qv_q});
	assign r  = word_t'({1'b0, r_q});

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign position_est = pos_est_q;
	assign velocity_est = vel_est_q;

	always_comb begin
		unique case (op_q)
			OP_T00:  begin opa = dt;    opb = p10_q; end
			OP_T01:  begin opa = dt;    opb = p11_q; end
			OP_A00:  begin opa = a01_q; opb = dt;    end
			OP_A10:  begin opa = p11_q; opb = dt;    end
			OP_XP:   begin opa = dt;    opb = vel_q; end
			OP_POS:  begin opa = k0_q;  opb = y_q;   end
			OP_VEL:  begin opa = k1_q;  opb = y_q;   end
			OP_P00:  begin opa = c_q;   opb = a00_q; end
			OP_P01:  begin opa = c_q;   opb = a01_q; end
			OP_P10:  begin opa = k1_q;  opb = a00_q; end
			OP_P11:  begin opa = k1_q;  opb = a01_q; end
			default: begin opa = '0;    opb = '0;    end
		endcase
	end

	assign mres   = sat_mul(prod_q);
	assign s_next = sat_add(a00_q, r);

	// one restoring step
	assign trial    = {rem_q, num_q[QUOT_W-1]};
	assign take     = (trial >= {1'b0, ms_q});
	assign rem_next = take ? word_t'(trial - {1'b0, ms_q}) : word_t'(trial[WORD_W-1:0]);
	assign num_next = {num_q[QUOT_W-2:0], take};
	assign div_last = (div_cnt_q == CNT_W'(DIV_STEPS - 1));
	assign kq       = (s_q == '0) ? '0 : sat_quot(num_next, neg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_T00;
			dt_q        <= RST_STEP_TIME;
			qp_q        <= RST_POSITION_NOISE;
			qv_q        <= RST_VELOCITY_NOISE;
			r_q         <= RST_MEASURE_NOISE;
			pos_q       <= '0;
			vel_q       <= '0;
			p00_q       <= ONE;
			p01_q       <= '0;
			p10_q       <= '0;
			p11_q       <= ONE;
			pos_est_q   <= '0;
			vel_est_q   <= '0;
			out_valid_q <= 1'b0;
			ksel_q      <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_STEP_TIME:      dt_q <= cfg_data;
					REG_POSITION_NOISE: qp_q <= cfg_data;
					REG_VELOCITY_NOISE: qv_q <= cfg_data;
					REG_MEASURE_NOISE:  r_q  <= cfg_data;
				endcase
			end
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= OP_T00;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					unique case (op_q)
						OP_POS:  pos_q <= sat_add(xp_q, mres);
						OP_VEL:  vel_q <= sat_add(vel_q, mres);
						OP_P00:  p00_q <= mres;
						OP_P01:  p01_q <= mres;
						OP_P10:  p10_q <= sat_sub(a10_q, mres);
						OP_P11:  p11_q <= sat_sub(a11_q, mres);
						default: ;
					endcase
					if (op_q == OP_XP) begin
						ksel_q    <= 1'b0;
						div_cnt_q <= '0;
						state_q   <= S_DIV;
					end else if (op_q == OP_P11) begin
						state_q <= S_OUT;
					end else begin
						op_q    <= op_t'(op_q + 4'd1);
						state_q <= S_MUL;
					end
				end
				S_DIV: begin
					div_cnt_q <= div_last ? '0 : div_cnt_q + CNT_W'(1);
					if (div_last) begin
						if (ksel_q) begin
							op_q    <= OP_POS;
							state_q <= S_MUL;
						end
						ksel_q <= 1'b1;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						pos_est_q   <= pos_q;
						vel_est_q   <= vel_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			meas_q <= measurement;
		end
		if (state_q == S_MUL) begin
			prod_q <= prod_t'(opa) * prod_t'(opb);
		end
		if (state_q == S_ACC) begin
			unique case (op_q)
				OP_T00: a00_q <= sat_add(p00_q, mres);
				OP_T01: a01_q <= sat_add(p01_q, mres);
				OP_A00: a00_q <= sat_add(sat_add(a00_q, mres), qp);
				OP_A10: begin
					a10_q <= sat_add(p10_q, mres);
					a11_q <= sat_add(p11_q, qv);
				end
				OP_XP: begin
					xp_q  <= sat_add(pos_q, mres);
					s_q   <= s_next;
					rem_q <= '0;
					ms_q  <= abs_word(s_next);
					neg_q <= a00_q[WORD_W-1] ^ s_next[WORD_W-1];
					num_q <= {abs_word(a00_q), {FRAC_BITS{1'b0}}};
				end
				OP_POS:  c_q <= sat_sub(ONE, k0_q);
				default: ;
			endcase
		end
		if (state_q == S_DIV) begin
			y_q <= sat_sub(meas_q, xp_q);
			if (div_last) begin
				if (ksel_q) begin
					k1_q <= kq;
				end else begin
					k0_q  <= kq;
					rem_q <= '0;
					neg_q <= a10_q[WORD_W-1] ^ s_q[WORD_W-1];
					num_q <= {abs_word(a10_q), {FRAC_BITS{1'b0}}};
				end
			end else begin
				rem_q <= rem_next;
				num_q <= num_next;
			end
		end
	end

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a computation was starting");

	a_mul_then_acc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |=> state_q == S_ACC)
		else $error("product not accumulated after multiply");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_DIV |-> div_cnt_q == '0)
		else $error("divider count left running outside division");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && out_valid_q && out_stall |=> state_q == S_OUT)
		else $error("result dropped while output word was stalled");

endmodule

FILE: bench/tb_position_velocity_kalman_filter.sv
`timescale 1ns / 100ps

module tb_position_velocity_kalman_filter;
	import pvkf_pkg::*;

	typedef struct packed {
		word_t position;
		word_t velocity;
	} estimate_t;

	class track_scoreboard;
		estimate_t pending_estimates[$];
		longint step_time, position_noise, velocity_noise, measure_noise;
		longint track_position, track_velocity;
		longint cov[4];
		int mismatches;
		int checked;

		function new();
			step_time = longint'(RST_STEP_TIME);
			position_noise = longint'(RST_POSITION_NOISE);
			velocity_noise = longint'(RST_VELOCITY_NOISE);
			measure_noise = longint'(RST_MEASURE_NOISE);
			track_position = 0;
			track_velocity = 0;
			cov[0] = longint'(ONE);
			cov[1] = 0;
			cov[2] = 0;
			cov[3] = longint'(ONE);
			mismatches = 0;
			checked = 0;
		endfunction

		static function longint clamp_word(longint v);
			if (v > longint'(WORD_MAX)) begin
				return longint'(WORD_MAX);
			end
			if (v < longint'(WORD_MIN)) begin
				return longint'(WORD_MIN);
			end
			return v;
		endfunction

		static function longint fixed_mul(longint a, longint b);
			return clamp_word((a * b) >>> FRAC_BITS);
		endfunction

		static function longint fixed_div(longint a, longint s);
			return clamp_word((a <<< FRAC_BITS) / s);
		endfunction

		function void set_register(cfg_index_t index, cfg_word_t value);
			case (index)
				REG_STEP_TIME: begin
					step_time = longint'(value);
				end
				REG_POSITION_NOISE: begin
					position_noise = longint'(value);
				end
				REG_VELOCITY_NOISE: begin
					velocity_noise = longint'(value);
				end
				REG_MEASURE_NOISE: begin
					measure_noise = longint'(value);
				end
				default: begin
				end
			endcase
		endfunction

		function void note_measurement(word_t value);
			longint dt, t00, t01, a00, a01, a10, a11, xp, s, k0, k1, y, c;
			estimate_t e;
			dt = step_time;
			t00 = clamp_word(cov[0] + fixed_mul(dt, cov[2]));
			t01 = clamp_word(cov[1] + fixed_mul(dt, cov[3]));
			a00 = clamp_word(clamp_word(t00 + fixed_mul(t01, dt)) + position_noise);
			a01 = t01;
			a10 = clamp_word(cov[2] + fixed_mul(cov[3], dt));
			a11 = clamp_word(cov[3] + velocity_noise);
			xp = clamp_word(track_position + fixed_mul(dt, track_velocity));
			s = clamp_word(a00 + measure_noise);
			k0 = 0;
			k1 = 0;
			// no gain when the innovation variance is zero
			if (s != 0) begin
				k0 = fixed_div(a00, s);
				k1 = fixed_div(a10, s);
			end
			y = clamp_word(longint'(value) - xp);
			track_position = clamp_word(xp + fixed_mul(k0, y));
			track_velocity = clamp_word(track_velocity + fixed_mul(k1, y));
			c = clamp_word(longint'(ONE) - k0);
			cov[0] = fixed_mul(c, a00);
			cov[1] = fixed_mul(c, a01);
			cov[2] = clamp_word(a10 - fixed_mul(k1, a00));
			cov[3] = clamp_word(a11 - fixed_mul(k1, a01));
			e.position = word_t'(track_position);
			e.velocity = word_t'(track_velocity);
			pending_estimates.push_back(e);
		endfunction

		function void check_estimate(word_t position, word_t velocity);
			estimate_t e;
			checked++;
			if (pending_estimates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected estimate word: position %0d velocity %0d",
						position, velocity);
				end
				return;
			end
			e = pending_estimates.pop_front();
			if (position !== e.position || velocity !== e.velocity) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("estimate %0d: position exp %0d got %0d, velocity exp %0d got %0d",
						checked, e.position, position, e.velocity, velocity);
				end
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	cfg_index_t cfg_index;
	cfg_word_t  cfg_data;
	logic       in_valid;
	logic       in_stall;
	word_t      measurement;
	logic       out_valid;
	logic       out_stall;
	word_t      position_est;
	word_t      velocity_est;

	track_scoreboard sb;
	bit steady;
	int sent;
	int settings;

	position_velocity_kalman_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.measurement(measurement),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.position_est(position_est),
		.velocity_est(velocity_est)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic send_measurement(input word_t value);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		measurement <= value;
		do @(posedge clk); while (in_stall);
		sb.note_measurement(value);
		sent++;
	endtask

	task automatic drain_estimates();
		in_valid <= 1'b0;
		while (sb.pending_estimates.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(input cfg_index_t index, input cfg_word_t value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		sb.set_register(index, value);
	endtask

	task automatic program_filter(input cfg_word_t dt, input cfg_word_t qp,
			input cfg_word_t qv, input cfg_word_t r);
		drain_estimates();
		repeat (4) @(posedge clk);
		write_register(REG_STEP_TIME, dt);
		write_register(REG_POSITION_NOISE, qp);
		write_register(REG_VELOCITY_NOISE, qv);
		write_register(REG_MEASURE_NOISE, r);
		cfg_we <= 1'b0;
		settings++;
	endtask

	function automatic cfg_word_t draw_setting(input int unsigned typical_max,
			input bit at_least_one);
		cfg_word_t v;
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			2: v = cfg_word_t'($urandom);
			default: v = cfg_word_t'($urandom_range(0, typical_max));
		endcase
		if (at_least_one && v == '0) begin
			v = cfg_word_t'(1);
		end
		return v;
	endfunction

	task automatic send_corners(input int count);
		word_t corners[8];
		corners = '{32'sd0, WORD_MAX, WORD_MIN, -32'sd1, 32'sd1, 32'sh5555_5555,
			32'shAAAA_AAAA, ONE};
		for (int i = 0; i < count; i++) begin
			send_measurement(corners[i]);
		end
	endtask

	// mostly noisy constant-velocity tracks, some raw full-range words
	task automatic send_track(input int count);
		longint pos, vel, amp, m;
		pos = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
		vel = longint'($urandom_range(0, 1 << 19)) - (1 << 18);
		amp = longint'(1) << $urandom_range(2, 16);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				m = longint'(word_t'($urandom));
			end else begin
				if ($urandom_range(0, 39) == 0) begin
					vel = longint'($urandom_range(0, 1 << 19)) - (1 << 18);
				end
				pos = track_scoreboard::clamp_word(pos + vel);
				m = track_scoreboard::clamp_word(pos
					+ longint'($urandom_range(0, 2 * amp)) - amp);
			end
			send_measurement(word_t'(m));
		end
	endtask

	initial begin : drain_side
		int hold;
		forever begin
			hold = steady ? 0 : $urandom_range(0, 4);
			out_stall <= (hold != 0);
			@(posedge clk);
			while (!(out_valid && !out_stall)) begin
				if (out_valid && hold > 0) begin
					hold--;
				end
				if (hold == 0) begin
					out_stall <= 1'b0;
				end
				@(posedge clk);
			end
			sb.check_estimate(position_est, velocity_est);
		end
	end

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		sb = new();
		steady = 1'b0;
		sent = 0;
		settings = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_STEP_TIME;
		cfg_data <= '0;
		in_valid <= 1'b0;
		measurement <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_corners(8);
		program_filter('0, '0, '0, cfg_word_t'(1));
		send_corners(4);
		program_filter('1, '1, '1, '1);
		send_corners(4);
		program_filter('1, '0, '0, cfg_word_t'(1));
		send_corners(4);
		program_filter('0, '1, '1, '1);
		send_corners(4);

		for (int phase = 0; phase < 12; phase++) begin
			program_filter(draw_setting(1 << 18, 1'b0), draw_setting(1 << 17, 1'b0),
				draw_setting(1 << 17, 1'b0), draw_setting(1 << 20, 1'b1));
			steady = ($urandom_range(0, 3) == 0);
			send_track(100);
		end

		drain_estimates();
		steady = 1'b0;
		repeat (130) @(posedge clk);
		$display("%0d measurement words under %0d register settings, %0d estimates checked",
			sent, settings, sb.checked);
		$display("corner words, extreme settings and noisy tracks, %0d mismatches",
			sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: position_velocity_kalman_filter.f
design/pvkf_pkg.sv
design/position_velocity_kalman_filter.sv
bench/tb_position_velocity_kalman_filter.sv
